// ===== rtl/core/rgb_to_hsl_converter_macros.svh =====
// ----------------------------------------------------------------------------
// rgb to hsl converter assertion macros
// shared concurrent checks, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// same-cycle implication
`define RGBHSL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_to_hsl_converter check failed");

// next-cycle implication
`define RGBHSL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_to_hsl_converter check failed");

`endif

// ===== rtl/core/rgbhsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb to hsl package
// word and lane types shared by the front stage, the divider cells and the top
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

    localparam int LANES = 3;
    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;
    localparam int LANE_LIG = 2;

    localparam int CH_W   = 8;
    localparam int NUM_W  = 11;
    localparam int DEN_W  = 11;
    localparam int REM_W  = 11;
    localparam int DVD_W  = 17;
    localparam int QUO_W  = 17;
    localparam int OUT_W  = 16;

    localparam logic [DEN_W-1:0] LIG_DEN = DEN_W'(510);
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // one restoring division in flight
    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [REM_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
        logic [QUO_W-1:0] quo;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lanes;
        logic              achrom;
        logic [CH_W-1:0]   alpha;
    } word_t;

    // dividend is num * 65536 + den / 2; the top bits start as partial remainder
    function automatic lane_t lane_init(logic [NUM_W-1:0] num, logic [DEN_W-1:0] den);
        lane_t l;
        l.den = den;
        l.rem = {1'b0, num[NUM_W-1:1]};
        l.dvd = {num[0], 6'b0, den[DEN_W-1:1]};
        l.quo = '0;
        return l;
    endfunction

endpackage

// ===== rtl/core/rgbhsl_prep.sv =====
// ----------------------------------------------------------------------------
// rgb to hsl front stage
// finds max and min, forms numerators and divisors for the divider chain
// ----------------------------------------------------------------------------
module rgbhsl_prep
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    input  logic [rgbhsl_pkg::CH_W-1:0]    red,
    input  logic [rgbhsl_pkg::CH_W-1:0]    green,
    input  logic [rgbhsl_pkg::CH_W-1:0]    blue,
    input  logic [rgbhsl_pkg::CH_W-1:0]    alpha,
    output logic                           up_ready,
    output logic                           dn_valid,
    output rgbhsl_pkg::word_t              dn_word,
    input  logic                           dn_ready
);

    logic              valid_reg;
    logic              valid_next;
    rgbhsl_pkg::word_t word_reg;
    rgbhsl_pkg::word_t word_next;

    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [8:0]  sum;
    logic [7:0]  d;
    logic [8:0]  sat_den;
    logic [11:0] h;
    logic [10:0] six_d;

    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        sum     = {1'b0, mx} + {1'b0, mn};
        d       = mx - mn;
        six_d   = {1'b0, d, 2'b0} + {2'b0, d, 1'b0};
        sat_den = (sum > 9'd255) ? (9'd510 - sum) : sum;

        // hue numerator, never negative; blue wins ties, then green
        if (mx == blue)
        begin
            h = {2'b0, d, 2'b0} + {4'b0, red} - {4'b0, green};
        end
        else if (mx == green)
        begin
            h = {3'b0, d, 1'b0} + {4'b0, blue} - {4'b0, red};
        end
        else
        begin
            h = {4'b0, green} - {4'b0, blue};
            if (green < blue)
            begin
                h = h + {1'b0, six_d};
            end
        end

        word_next.lanes[rgbhsl_pkg::LANE_HUE] = rgbhsl_pkg::lane_init(h[10:0], six_d);
        word_next.lanes[rgbhsl_pkg::LANE_SAT] =
            rgbhsl_pkg::lane_init({3'b0, d}, {2'b0, sat_den});
        word_next.lanes[rgbhsl_pkg::LANE_LIG] =
            rgbhsl_pkg::lane_init({2'b0, sum}, rgbhsl_pkg::LIG_DEN);
        word_next.achrom = (d == 8'd0);
        word_next.alpha  = alpha;
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

// ===== rtl/core/rgbhsl_cell.sv =====
// ----------------------------------------------------------------------------
// rgb to hsl divider cell
// one restoring division step per lane, one quotient bit per cell
// ----------------------------------------------------------------------------
module rgbhsl_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    input  rgbhsl_pkg::word_t up_word,
    output logic              up_ready,
    output logic              dn_valid,
    output rgbhsl_pkg::word_t dn_word,
    input  logic              dn_ready
);

    logic              valid_reg;
    logic              valid_next;
    rgbhsl_pkg::word_t word_reg;
    rgbhsl_pkg::word_t word_next;

    logic [rgbhsl_pkg::REM_W:0] r2   [rgbhsl_pkg::LANES];
    logic [rgbhsl_pkg::REM_W:0] diff [rgbhsl_pkg::LANES];
    logic                       ge   [rgbhsl_pkg::LANES];

    always_comb
    begin
        word_next = up_word;
        for (int k = 0; k < rgbhsl_pkg::LANES; k++)
        begin
            // bring down the next dividend bit
            r2[k]   = {up_word.lanes[k].rem, up_word.lanes[k].dvd[rgbhsl_pkg::DVD_W-1]};
            diff[k] = r2[k] - {1'b0, up_word.lanes[k].den};
            ge[k]   = (r2[k] >= {1'b0, up_word.lanes[k].den});
            word_next.lanes[k].rem = ge[k] ? diff[k][rgbhsl_pkg::REM_W-1:0]
                                           : r2[k][rgbhsl_pkg::REM_W-1:0];
            word_next.lanes[k].dvd = {up_word.lanes[k].dvd[rgbhsl_pkg::DVD_W-2:0], 1'b0};
            word_next.lanes[k].quo = {up_word.lanes[k].quo[rgbhsl_pkg::QUO_W-2:0], ge[k]};
        end
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

// ===== rtl/core/rgb_to_hsl_converter.sv =====
// ----------------------------------------------------------------------------
// rgb to hsl converter
// pixel stream conversion from 8-bit rgb plus alpha to 16-bit hsl
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while pixel_stall is low and returns one hsl
// word per pixel, in order, through one front stage that finds max and min, a
// chain of 17 divider cells that each settle one quotient bit of the hue,
// saturation and lightness divisions, and one output register that clamps
// and masks. Throughput is one word per clock as long as result_stall stays
// low; pixel_stall rises only when every stage holds a word and the output
// is stalled. Hue is a fraction of a full turn, saturation and lightness
// are Q0.16, all rounded to nearest and clamped to 65535; gray pixels give
// hue and saturation of zero.

`include "rgb_to_hsl_converter_macros.svh"

module rgb_to_hsl_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  alpha,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] hue,
    output logic [15:0] saturation,
    output logic [15:0] lightness,
    output logic [7:0]  alpha_out
);

    localparam int STAGES = rgbhsl_pkg::QUO_W;

    logic              chain_valid [STAGES+1];
    logic              chain_ready [STAGES+1];
    rgbhsl_pkg::word_t chain_word  [STAGES+1];

    logic        prep_ready;
    logic        out_ready;
    logic        result_valid_reg;
    logic        result_valid_next;
    logic [15:0] hue_reg;
    logic [15:0] saturation_reg;
    logic [15:0] lightness_reg;
    logic [7:0]  alpha_reg;
    logic [15:0] q_clamped [rgbhsl_pkg::LANES];

    rgbhsl_prep u_prep
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pixel_valid),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .alpha    (alpha),
        .up_ready (prep_ready),
        .dn_valid (chain_valid[0]),
        .dn_word  (chain_word[0]),
        .dn_ready (chain_ready[0])
    );

    assign pixel_stall = !prep_ready;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        rgbhsl_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_word  (chain_word[i]),
            .up_ready (chain_ready[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_word  (chain_word[i+1]),
            .dn_ready (chain_ready[i+1])
        );
    end

    // quotient reaches 65536 only on full scale results
    always_comb
    begin
        for (int k = 0; k < rgbhsl_pkg::LANES; k++)
        begin
            q_clamped[k] = chain_word[STAGES].lanes[k].quo[rgbhsl_pkg::QUO_W-1]
                         ? rgbhsl_pkg::OUT_MAX
                         : chain_word[STAGES].lanes[k].quo[rgbhsl_pkg::OUT_W-1:0];
        end
    end

    assign out_ready            = !result_valid_reg || !result_stall;
    assign chain_ready[STAGES]  = out_ready;
    assign result_valid_next    = out_ready ? chain_valid[STAGES] : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[STAGES] && out_ready)
        begin
            // gray pixels have no hue or saturation
            hue_reg        <= chain_word[STAGES].achrom ? 16'd0
                                                        : q_clamped[rgbhsl_pkg::LANE_HUE];
            saturation_reg <= chain_word[STAGES].achrom ? 16'd0
                                                        : q_clamped[rgbhsl_pkg::LANE_SAT];
            lightness_reg  <= q_clamped[rgbhsl_pkg::LANE_LIG];
            alpha_reg      <= chain_word[STAGES].alpha;
        end
    end

    assign result_valid = result_valid_reg;
    assign hue          = hue_reg;
    assign saturation   = saturation_reg;
    assign lightness    = lightness_reg;
    assign alpha_out    = alpha_reg;

    `RGBHSL_ASSERT_NEXT(a_accept_enters_chain, pixel_valid && !pixel_stall, chain_valid[0])
    `RGBHSL_ASSERT_NOW(a_stall_only_when_full, pixel_stall, result_valid && result_stall)
    `RGBHSL_ASSERT_NOW(a_hue_implies_sat, result_valid && (hue != 16'd0), saturation != 16'd0)

endmodule
